>>> rtl/core/tfe_pkg.sv
// Package for the telemetry frame encoder: frame constants, word types and
// the structs passed between the front end, the frame queue and the serializer.
// Depends on nothing.
package tfe_pkg;

   localparam int FRAME_LEN  = 14;
   localparam int LAST_IDX   = FRAME_LEN - 1;
   localparam int IDX_W      = $clog2(FRAME_LEN);
   localparam int NUM_VALUES = 4;
   localparam int VALUE_W    = 33;
   localparam int MAG_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int HUND_W     = 7;
   localparam int PROD_W     = FRAC_W + HUND_W;

   localparam logic [PROD_W-1:0] HUND_SCALE = PROD_W'(100);

   typedef logic [7:0]           frame_byte_type;
   typedef logic [VALUE_W-1:0]   value_type;
   typedef logic [MAG_W-1:0]     mag_type;
   typedef logic [IDX_W-1:0]     idx_type;

   // Fourteen bytes of one frame, index 0 first on the wire.
   typedef frame_byte_type [FRAME_LEN-1:0] frame_type;

   // First front stage: id, magnitudes and the zero-or-below flags.
   typedef struct packed {
      frame_byte_type                 frame_id;
      mag_type [NUM_VALUES-1:0]       mag;
      logic [NUM_VALUES-1:0]          nonpos;
   } mag_stage_type;

   // Write side of the frame queue.
   typedef struct packed {
      logic      valid;
      frame_type frame;
   } fq_wr_type;

   // Read side of the frame queue: the head entry.
   typedef struct packed {
      logic      valid;
      frame_type frame;
   } fq_rd_type;

endpackage

>>> rtl/core/tfe_channels.sv
// Channel interfaces of the telemetry frame encoder: input item and result byte.
// Depends on nothing.
interface tfe_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_id;
   logic [32:0] value_a;
   logic [32:0] value_b;
   logic [32:0] value_c;
   logic [32:0] value_d;

   modport source (output valid, output frame_id, output value_a, output value_b,
                   output value_c, output value_d, input ready);
   modport sink (input valid, input frame_id, input value_a, input value_b,
                 input value_c, input value_d, output ready);
endinterface

interface tfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;

   modport source (output valid, output out_byte, output frame_end, input ready);
   modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

>>> rtl/core/tfe_front.sv
// Front end: accepts input words and builds the complete frame in two stages.
// Depends on tfe_pkg.
module tfe_front
   import tfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  frame_byte_type in_frame_id,
   input  value_type     in_value [NUM_VALUES],
   output fq_wr_type     wr,
   input  logic          wr_ready
);

   logic          s1_valid_ff, s1_valid_in;
   mag_stage_type s1_ff, s1_in;
   logic          s2_valid_ff, s2_valid_in;
   frame_type     s2_ff, s2_in;
   logic          s1_move, s2_move, s1_load;
   logic [7:0]    sum_l1 [7];
   logic [7:0]    sum_l2 [4];
   logic [7:0]    sum_l3 [2];

   // Stall chain: each stage moves on when the one after it has room.
   assign s2_move  = s2_valid_ff && wr_ready;
   assign s1_move  = s1_valid_ff && (!s2_valid_ff || s2_move);
   assign in_ready = !s1_valid_ff || s1_move;
   assign s1_load  = in_valid && in_ready;

   // Stage one: magnitude of each value and its zero-or-below flag.
   always_comb begin
      logic [VALUE_W-1:0] neg_v;
      s1_in = s1_ff;
      s1_in.frame_id = in_frame_id;
      for (int i = 0; i < NUM_VALUES; i++) begin
         neg_v = VALUE_W'(0) - in_value[i];
         s1_in.mag[i]    = in_value[i][VALUE_W-1] ? neg_v[MAG_W-1:0]
                                                  : in_value[i][MAG_W-1:0];
         s1_in.nonpos[i] = in_value[i][VALUE_W-1] || (in_value[i] == '0);
      end
   end

   assign s1_valid_in = s1_load ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   // Stage two: three bytes per value, with hundredths from the fraction.
   always_comb begin
      logic [PROD_W-1:0] prod;
      s2_in = s2_ff;
      s2_in[0] = s1_ff.frame_id;
      for (int i = 0; i < NUM_VALUES; i++) begin
         prod = PROD_W'(s1_ff.mag[i][FRAC_W-1:0]) * HUND_SCALE;
         s2_in[1 + 3 * i] = s1_ff.mag[i][MAG_W-1:MAG_W-8];
         s2_in[2 + 3 * i] = s1_ff.mag[i][FRAC_W+7:FRAC_W];
         s2_in[3 + 3 * i] = {s1_ff.nonpos[i], prod[PROD_W-1:FRAC_W]};
      end
      s2_in[LAST_IDX] = '0;
   end

   assign s2_valid_in = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         s2_ff <= s2_in;
      end
   end

   // Checksum over bytes 0 to 12 as a balanced adder tree.
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         sum_l1[i] = s2_ff[2 * i] + s2_ff[2 * i + 1];
      end
      sum_l1[6] = s2_ff[LAST_IDX - 1];
      for (int i = 0; i < 3; i++) begin
         sum_l2[i] = sum_l1[2 * i] + sum_l1[2 * i + 1];
      end
      sum_l2[3] = sum_l1[6];
      for (int i = 0; i < 2; i++) begin
         sum_l3[i] = sum_l2[2 * i] + sum_l2[2 * i + 1];
      end
   end

   always_comb begin
      wr.valid = s2_valid_ff;
      wr.frame = s2_ff;
      wr.frame[LAST_IDX] = sum_l3[0] + sum_l3[1];
   end

   // A stage that is blocked keeps its word.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("front stage one lost or changed a blocked word");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !wr_ready) |=> (s2_valid_ff && $stable(s2_ff)))
      else $error("front stage two lost or changed a blocked frame");

endmodule

>>> rtl/core/tfe_queue.sv
// Frame queue between the front end and the serializer, held in registers.
// Depends on tfe_pkg.
module tfe_queue
   import tfe_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  fq_wr_type wr,
   output logic      wr_ready,
   output fq_rd_type rd,
   input  logic      pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   frame_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, do_pop;

   assign wr_ready = (count_ff != FULL_CNT);
   assign push     = wr.valid && wr_ready;
   assign do_pop   = pop && (count_ff != '0);

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = push ? ((wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ((rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr.frame;
      end
   end

   assign rd.valid = (count_ff != '0);
   assign rd.frame = entry_ff[rd_ptr_ff];

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("frame queue count beyond its depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("frame queue count missed a write");

endmodule

>>> rtl/core/tfe_back.sv
// Serializer: sends the head frame of the queue one byte per word through
// an output register. Depends on tfe_pkg.
module tfe_back
   import tfe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  fq_rd_type      rd,
   output logic           pop,
   output logic           out_valid,
   input  logic           out_ready,
   output frame_byte_type out_byte,
   output logic           out_end
);

   idx_type        idx_ff, idx_in;
   logic           valid_ff, valid_in;
   frame_byte_type byte_ff;
   logic           end_ff;
   logic           load, emit, last;

   // The output register takes a new byte when empty or being drained.
   assign load = !valid_ff || out_ready;
   assign emit = load && rd.valid;
   assign last = (idx_ff == idx_type'(LAST_IDX));
   assign pop  = emit && last;

   assign idx_in   = emit ? (last ? '0 : idx_ff + 1'b1) : idx_ff;
   assign valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= rd.frame[idx_ff];
         end_ff  <= last;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_end   = end_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= idx_type'(LAST_IDX))
      else $error("byte index beyond the frame");

   a_wrap: assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == '0 && out_end))
      else $error("serializer did not restart after the checksum byte");

endmodule

>>> rtl/core/telemetry_frame_encoder.sv
// Channel  | Dir | Payload                                      | Moves
// req_chan | in  | frame_id, value_a, value_b, value_c, value_d | one item per word
// rsp_chan | out | out_byte, frame_end                          | one frame byte per word
//
// Each item gives fourteen words on rsp_chan, so the sustained item rate is set
// by the byte-wide output register of the serializer.
// The front end takes one word per cycle until the frame queue fills; the first
// byte of a frame passes stage one, stage two, the queue and the output register.
// Reset (synchronous, active high) empties the pipeline and the queue.
// Either side may stall at any time; the queue lets the front keep working.
//
// Top level of the telemetry frame encoder. Depends on tfe_pkg, tfe_channels,
// tfe_front, tfe_queue and tfe_back.
module telemetry_frame_encoder
   import tfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   tfe_req_if.sink          req_chan,
   tfe_rsp_if.source        rsp_chan
);

   value_type  req_values [NUM_VALUES];
   fq_wr_type  fq_wr;
   fq_rd_type  fq_rd;
   logic       fq_wr_ready;
   logic       fq_pop;

   assign req_values[0] = req_chan.value_a;
   assign req_values[1] = req_chan.value_b;
   assign req_values[2] = req_chan.value_c;
   assign req_values[3] = req_chan.value_d;

   // Front end: magnitudes, hundredths and checksum.
   tfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_frame_id (req_chan.frame_id),
      .in_value    (req_values),
      .wr          (fq_wr),
      .wr_ready    (fq_wr_ready)
   );

   // Frame queue between the two halves.
   tfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (fq_wr),
      .wr_ready (fq_wr_ready),
      .rd       (fq_rd),
      .pop      (fq_pop)
   );

   // Back end: byte serializer.
   tfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rd        (fq_rd),
      .pop       (fq_pop),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_byte  (rsp_chan.out_byte),
      .out_end   (rsp_chan.frame_end)
   );

endmodule

>>> test/tfe_frame_checker.sv
`timescale 1ns / 1ps
// Frame checker for the telemetry frame encoder: watches both channels, predicts
// the fourteen frame bytes of every accepted item and compares them in order.
// Depends on tfe_pkg and the channel interfaces in tfe_channels.
module tfe_frame_checker
   import tfe_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tfe_req_if   req_mon,
   tfe_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   bytes_pending,
   output int   bytes_checked,
   output int   frames_checked
);

   // One expected result word: the byte, its end-of-frame flag and its place in the frame.
   typedef struct packed {
      frame_byte_type data;
      logic           last;
      idx_type        pos;
   } frame_word_type;

   frame_word_type pending_words[$];
   int             error_total;
   int             byte_total;
   int             frame_total;

   // Three bytes for one value: integer magnitude high byte first, then the
   // zero-or-below flag over the truncated hundredths of the fraction.
   function automatic logic [23:0] encode_value(input value_type raw);
      value_type   mag;
      logic [22:0] scaled;
      logic        nonpos;
      nonpos = raw[VALUE_W-1] || (raw == '0);
      mag    = raw[VALUE_W-1] ? -raw : raw;
      scaled = mag[FRAC_W-1:0] * 23'd100;
      return {mag[31:16], nonpos, scaled[22:16]};
   endfunction

   // Whole frame for one item, checksum byte included.
   function automatic frame_type encode_frame(input frame_byte_type id, input value_type a,
                                              input value_type b, input value_type c,
                                              input value_type d);
      value_type      vals [NUM_VALUES];
      logic [23:0]    enc;
      frame_type      frame;
      frame_byte_type sum;
      vals = '{a, b, c, d};
      frame[0] = id;
      for (int i = 0; i < NUM_VALUES; i++) begin
         enc = encode_value(vals[i]);
         frame[1 + 3 * i] = enc[23:16];
         frame[2 + 3 * i] = enc[15:8];
         frame[3 + 3 * i] = enc[7:0];
      end
      sum = '0;
      for (int i = 0; i < LAST_IDX; i++)
         sum += frame[i];
      frame[LAST_IDX] = sum;
      return frame;
   endfunction

   // Inputs are sampled at the edge, so both sides see the values that the edge accepts.
   always @(posedge clock) begin
      frame_type      frame;
      frame_word_type w;
      if (reset) begin
         pending_words.delete();
         error_total = 0;
         byte_total  = 0;
         frame_total = 0;
      end else begin
         // An accepted item queues its fourteen bytes.
         if (req_mon.valid && req_mon.ready) begin
            frame = encode_frame(req_mon.frame_id, req_mon.value_a, req_mon.value_b,
                                 req_mon.value_c, req_mon.value_d);
            for (int k = 0; k < FRAME_LEN; k++) begin
               w.data = frame[k];
               w.last = (k == LAST_IDX);
               w.pos  = idx_type'(k);
               pending_words.push_back(w);
            end
         end
         // An accepted result word is matched against the oldest expected byte.
         if (rsp_mon.valid && rsp_mon.ready) begin
            byte_total++;
            if (pending_words.size() == 0) begin
               error_total++;
               $error("unexpected result word: out_byte %02h, frame_end %0b",
                      rsp_mon.out_byte, rsp_mon.frame_end);
            end else begin
               w = pending_words.pop_front();
               if (rsp_mon.out_byte !== w.data) begin
                  error_total++;
                  $error("out_byte (frame byte %0d): expected %02h, actual %02h",
                         w.pos, w.data, rsp_mon.out_byte);
               end
               if (rsp_mon.frame_end !== w.last) begin
                  error_total++;
                  $error("frame_end (frame byte %0d): expected %0b, actual %0b",
                         w.pos, w.last, rsp_mon.frame_end);
               end
               if (w.last)
                  frame_total++;
            end
         end
      end
      mismatch_count <= error_total;
      bytes_pending  <= pending_words.size();
      bytes_checked  <= byte_total;
      frames_checked <= frame_total;
   end

endmodule

>>> test/telemetry_frame_encoder_test.sv
`timescale 1ns / 1ps
// Top of the telemetry frame encoder testbench: clock, reset, item stimulus,
// result back-pressure and the verdict. Depends on tfe_pkg, tfe_channels,
// the encoder RTL and tfe_frame_checker.
module telemetry_frame_encoder_test
   import tfe_pkg::*;
();

   localparam int RANDOM_ITEMS = 450;
   localparam int HOLD_CYCLES  = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfe_req_if req_chan ();
   tfe_rsp_if rsp_chan ();

   int   mismatch_count;
   int   bytes_pending;
   int   bytes_checked;
   int   frames_checked;
   int   items_sent = 0;
   int   directed_items = 0;
   int   burst_left = 0;
   logic hold_off_request = 1'b0;

   telemetry_frame_encoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tfe_frame_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending),
      .bytes_checked  (bytes_checked),
      .frames_checked (frames_checked)
   );

   always #6 clock = ~clock;

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offers one item and returns at the edge that accepts it.
   task automatic send_item(input frame_byte_type id, input value_type a, input value_type b,
                            input value_type c, input value_type d);
      req_chan.valid    <= 1'b1;
      req_chan.frame_id <= id;
      req_chan.value_a  <= a;
      req_chan.value_b  <= b;
      req_chan.value_c  <= c;
      req_chan.value_d  <= d;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Keeps valid high inside a burst; otherwise drops it for a random gap.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // Random value: mostly full range, some small magnitudes, zeros, extremes
   // and fractions close to a hundredths step.
   function automatic value_type random_value();
      int          pick;
      logic [31:0] mag;
      value_type   v;
      pick = $urandom_range(0, 9);
      mag  = $urandom();
      case (pick) inside
         [0:4]: begin
            v = {($urandom_range(0, 1) == 1), mag};
         end
         [5:6]: begin
            v = {1'b0, mag & 32'h00FF_FFFF};
            if ($urandom_range(0, 1) == 1)
               v = -v;
         end
         7: begin
            v = '0;
         end
         8: begin
            case ($urandom_range(0, 5))
               0: v = 33'h0_FFFF_FFFF;
               1: v = 33'h1_0000_0001;
               2: v = 33'h1_0000_0000;
               3: v = 33'h1_FFFF_FFFF;
               4: v = 33'h0_0000_0001;
               default: v = 33'h0_8000_0000;
            endcase
         end
         default: begin
            v = {1'b0, mag[31:16], 16'($urandom_range(0, 99) * 655 + $urandom_range(0, 2))};
            if ($urandom_range(0, 1) == 1)
               v = -v;
         end
      endcase
      return v;
   endfunction

   // Result side: segments of differing stall patterns, plus one long hold-off
   // once the sender starts its first long burst.
   initial begin
      int   mode;
      int   seg;
      int   hold_left;
      int   phase;
      logic hold_done;
      rsp_chan.ready = 1'b0;
      hold_left = 0;
      phase = 0;
      hold_done = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         seg  = $urandom_range(20, 120);
         repeat (seg) begin
            @(posedge clock);
            phase++;
            if (hold_off_request && !hold_done) begin
               hold_left = HOLD_CYCLES;
               hold_done = 1'b1;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_chan.ready <= 1'b0;
            end else begin
               case (mode)
                  0: rsp_chan.ready <= 1'b1;
                  1: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
                  2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_chan.ready <= (phase % 5 != 3);
               endcase
            end
         end
      end
   end

   // Item side: reset, directed items, random items, drain and verdict.
   initial begin
      req_chan.valid    = 1'b0;
      req_chan.frame_id = '0;
      req_chan.value_a  = '0;
      req_chan.value_b  = '0;
      req_chan.value_c  = '0;
      req_chan.value_d  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All zeros: every zero-or-below flag is set.
      send_item(8'h00, 33'h0, 33'h0, 33'h0, 33'h0);
      pace_sender();
      // Largest positive and most negative magnitudes, checksum wrapping.
      send_item(8'hFF, 33'h0_FFFF_FFFF, 33'h0_FFFF_FFFF, 33'h0_FFFF_FFFF, 33'h0_FFFF_FFFF);
      pace_sender();
      send_item(8'hA5, 33'h1_0000_0001, 33'h1_0000_0001, 33'h1_0000_0001, 33'h1_0000_0001);
      pace_sender();
      // Most negative pattern: its integer part overflows sixteen bits.
      send_item(8'h5A, 33'h1_0000_0000, 33'h1_0000_0000, 33'h1_0000_0000, 33'h1_0000_0000);
      pace_sender();
      // One LSB and one whole unit either side of zero.
      send_item(8'h01, 33'h0_0000_0001, 33'h1_FFFF_FFFF, 33'h0_0001_0000, 33'h1_FFFF_0000);
      pace_sender();
      // Hundredths just below and at the first step, and the top of the fraction.
      send_item(8'h80, 33'd655, 33'd656, 33'h0_0000_FFFF, 33'h1_FFFF_0001);
      pace_sender();
      // Mixed signs with zero and the most negative pattern in the same frame.
      send_item(8'h7F, 33'h0_8000_0000, 33'h1_8000_0000, 33'h0, 33'h1_0000_0000);
      pace_sender();
      send_item(8'h55, 33'h0_7FFF_FFFF, 33'h1_0000_8000, 33'h0_00FF_00FF, 33'h1_FF00_FF00);
      pace_sender();
      send_item(8'hAA, 33'h0_1234_5678, 33'h1_EDCB_A988, 33'h0_0000_8000, 33'h0_0001_FFFF);
      pace_sender();
      send_item(8'hC3, 33'h1_5555_5555, 33'h0_AAAA_AAAA, 33'h1_AAAA_AAAA, 33'h0_5555_5555);
      pace_sender();
      directed_items = items_sent;

      // Random part opens with a long burst against a long receiver hold-off.
      hold_off_request <= 1'b1;
      burst_left = 40;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_item(8'($urandom_range(0, 255)), random_value(), random_value(),
                   random_value(), random_value());
         pace_sender();
      end
      req_chan.valid <= 1'b0;

      // Let the last bytes drain, then a little longer for any stray word.
      @(posedge clock);
      while (bytes_pending != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Encoded %0d items (%0d directed, %0d random) under random gaps and stalls.",
               items_sent, directed_items, items_sent - directed_items);
      $display("Compared %0d frames, %0d result bytes; %0d mismatches.",
               frames_checked, bytes_checked, mismatch_count);
      if (mismatch_count == 0 && bytes_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
